/* sv/compass_heading_averager_assert.svh */
// Assertion macros for the compass heading averager checker.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef COMPASS_HEADING_AVERAGER_ASSERT_SVH
`define COMPASS_HEADING_AVERAGER_ASSERT_SVH

// Same-cycle implication, masked while reset is high
`define CHA_ASSERT_HOLD(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("compass heading averager: check failed");

// Next-cycle implication, masked while reset is high
`define CHA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("compass heading averager: check failed");

// Condition that must hold in the cycle after reset is sampled high
`define CHA_ASSERT_RESET(label, cons) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("compass heading averager: reset check failed");

`endif

/* sv/cha_pkg.sv */
// Shared constants, tables and types for the compass heading averager.
// No dependencies; imported by every RTL module of the block.
package cha_pkg;

   // Averaging group size and heading precision
   localparam int SAMPLES         = 10;
   localparam int ANGLE_FRAC_BITS = 8;

   // Input field and pre-rotated vector widths
   localparam int FIELD_W  = 12;
   localparam int VEC_IN_W = FIELD_W + 1;

   // CORDIC datapath
   localparam int CORDIC_STEPS = 16;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);
   localparam int TABLE_FRAC   = 16;
   localparam int VEC_W        = 32;
   localparam int ANG_W        = 26;
   localparam int ATAN_W       = 22;
   localparam int ANGLE_RIGHT  = 90 << TABLE_FRAC;

   // Heading rounding from Q16 down to the output precision
   localparam int ROUND_SHIFT = TABLE_FRAC - ANGLE_FRAC_BITS;
   localparam int ROUND_HALF  = (ROUND_SHIFT == 0) ? 0 : (1 << (ROUND_SHIFT - 1));

   // Fixed-point heading
   localparam int HEAD_W     = ANGLE_FRAC_BITS + 9;
   localparam int HEAD_LIM   = 180 << ANGLE_FRAC_BITS;
   localparam int HEAD_RIGHT = 90 << ANGLE_FRAC_BITS;

   // Running sum and group count
   localparam int SUM_W   = 12;
   localparam int SUM_MAX = 2047;
   localparam int SUM_MIN = -2048;
   localparam int TOT_W   = ANGLE_FRAC_BITS + SUM_W + 1;
   localparam int CNT_W   = $clog2(SAMPLES + 1);

   // Average by reciprocal multiply: exact for magnitudes below 2^12
   localparam int DIV_SHIFT = 24;
   localparam int RECIP     = ((1 << DIV_SHIFT) + SAMPLES - 1) / SAMPLES;
   localparam int RECIP_W   = DIV_SHIFT + 1;
   localparam int MAG_W     = SUM_W;
   localparam int PROD_W    = MAG_W + RECIP_W;

   // Result
   localparam int OUT_W   = 9;
   localparam int OUT_LIM = 180;

   // Queue depths
   localparam int QUEUE_DEPTH = 2;
   localparam int RSP_DEPTH   = 2;

   // atan(2^-i) in degrees, Q16
   localparam logic [ATAN_W-1:0] ATAN_Q16 [CORDIC_STEPS] = '{
      22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
      22'd234379,  22'd117304,  22'd58666,  22'd29335,
      22'd14668,   22'd7334,    22'd3667,   22'd1833,
      22'd917,     22'd458,     22'd229,    22'd115
   };

   // Starting angle after quadrant pre-rotation
   typedef enum logic [1:0] {
      START_ZERO,
      START_POS90,
      START_NEG90
   } start_type;

   // One classified reading, front to back
   typedef struct packed {
      logic                       special;
      logic signed [HEAD_W-1:0]   fixed_heading;
      logic signed [VEC_IN_W-1:0] vec_a;
      logic signed [VEC_IN_W-1:0] vec_b;
      start_type                  start;
   } work_type;

   // Back-end sequencer
   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_ROTATE = 6'b000010,
      ST_ROUND  = 6'b000100,
      ST_ACCUM  = 6'b001000,
      ST_AVG    = 6'b010000,
      ST_EMIT   = 6'b100000
   } back_state_type;

endpackage

/* sv/compass_heading_averager.sv */
// Top level of the compass heading averager: front, queue and back end.
// Depends on cha_pkg, cha_front, cha_queue and cha_back.
//
//   channel   direction  handshake        payload
//   req_      in         push / full      field_x, field_y (12-bit signed)
//   rsp_      out        pop / empty      heading_deg (9-bit signed)
//
// An ordinary reading passes through the back end as one load, 16 CORDIC
// rotations of the single shared rotator, one round and one accumulate.
// Axis and origin readings skip the rotator: load, then accumulate. Closing
// a group adds a reciprocal multiply, then a write to the result buffer.
// Synchronous reset empties both queues and clears the sum and count.
// req_full rises when the two-entry work queue fills; the back end holds in
// its emit step while the two-entry result buffer is full.
module compass_heading_averager import cha_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic signed [FIELD_W-1:0] req_field_x,
   input  logic signed [FIELD_W-1:0] req_field_y,
   input  logic                      rsp_pop,
   output logic                      rsp_empty,
   output logic signed [OUT_W-1:0]   rsp_heading_deg
);

   work_type write_data;
   work_type read_data;
   logic     queue_write;
   logic     queue_full;
   logic     queue_read;
   logic     queue_not_empty;

   cha_front u_front (
      .req_push    (req_push),
      .req_field_x (req_field_x),
      .req_field_y (req_field_y),
      .req_full    (req_full),
      .queue_full  (queue_full),
      .queue_write (queue_write),
      .queue_data  (write_data)
   );

   cha_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .write      (queue_write),
      .write_data (write_data),
      .read       (queue_read),
      .read_data  (read_data),
      .full       (queue_full),
      .not_empty  (queue_not_empty)
   );

   cha_back u_back (
      .clock           (clock),
      .reset           (reset),
      .work            (read_data),
      .work_valid      (queue_not_empty),
      .work_take       (queue_read),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_heading_deg (rsp_heading_deg)
   );

endmodule

/* sv/cha_front.sv */
// Front end: accepts readings and classifies axis and origin cases.
// Pre-rotates ordinary readings into the right half plane. Uses cha_pkg.
module cha_front import cha_pkg::*; (
   input  logic                      req_push,
   input  logic signed [FIELD_W-1:0] req_field_x,
   input  logic signed [FIELD_W-1:0] req_field_y,
   output logic                      req_full,
   input  logic                      queue_full,
   output logic                      queue_write,
   output work_type                  queue_data
);

   logic signed [VEC_IN_W-1:0] a_raw;
   logic signed [VEC_IN_W-1:0] b_raw;

   // Vector is (b, a) = (X, -Y)
   assign a_raw = -VEC_IN_W'(req_field_y);
   assign b_raw = VEC_IN_W'(req_field_x);

   assign req_full    = queue_full;
   assign queue_write = req_push && !queue_full;

   // Classify and pre-rotate
   always_comb begin
      queue_data               = '0;
      queue_data.vec_a         = a_raw;
      queue_data.vec_b         = b_raw;
      queue_data.start         = START_ZERO;
      if (a_raw == '0) begin
         // On the X axis (or origin): exact 0 or +180
         queue_data.special       = 1'b1;
         queue_data.fixed_heading = b_raw[VEC_IN_W-1] ? HEAD_W'(HEAD_LIM) : '0;
      end else if (b_raw == '0) begin
         // On the Y axis: exact +-90
         queue_data.special       = 1'b1;
         queue_data.fixed_heading = a_raw[VEC_IN_W-1] ? HEAD_W'(-HEAD_RIGHT)
                                                      : HEAD_W'(HEAD_RIGHT);
      end else if (b_raw[VEC_IN_W-1]) begin
         if (!a_raw[VEC_IN_W-1]) begin
            queue_data.vec_b = a_raw;
            queue_data.vec_a = -b_raw;
            queue_data.start = START_POS90;
         end else begin
            queue_data.vec_b = -a_raw;
            queue_data.vec_a = b_raw;
            queue_data.start = START_NEG90;
         end
      end
   end

endmodule

/* sv/cha_queue.sv */
// Short queue of classified readings between front and back end.
// Register-based, QUEUE_DEPTH entries of work_type. Uses cha_pkg.
module cha_queue import cha_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     write,
   input  work_type write_data,
   input  logic     read,
   output work_type read_data,
   output logic     full,
   output logic     not_empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   work_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_write, do_read;

   assign full      = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign read_data = entry_ff[rd_ptr_ff];
   assign do_write  = write && !full;
   assign do_read   = read && not_empty;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_write) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_read) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_write && !do_read) begin
         count_in = count_ff + 1'b1;
      end else if (do_read && !do_write) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store payload
   always_ff @(posedge clock) begin
      if (do_write) begin
         entry_ff[wr_ptr_ff] <= write_data;
      end
   end

endmodule

/* sv/cha_back.sv */
// Back end: iterative CORDIC, running sum, group average and result buffer.
// Takes classified readings from cha_queue. Uses cha_pkg.
module cha_back import cha_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  work_type                work,
   input  logic                    work_valid,
   output logic                    work_take,
   input  logic                    rsp_pop,
   output logic                    rsp_empty,
   output logic signed [OUT_W-1:0] rsp_heading_deg
);

   localparam int RPTR_W = $clog2(RSP_DEPTH);
   localparam int RCNT_W = $clog2(RSP_DEPTH + 1);

   localparam logic signed [ANG_W-1:0] ANG_HEAD_HI = ANG_W'(HEAD_LIM);
   localparam logic signed [ANG_W-1:0] ANG_HEAD_LO = ANG_W'(-HEAD_LIM);
   localparam logic signed [TOT_W-1:0] TOT_SUM_HI  = TOT_W'(SUM_MAX);
   localparam logic signed [TOT_W-1:0] TOT_SUM_LO  = TOT_W'(SUM_MIN);
   localparam logic signed [MAG_W:0]   AVG_HI      = (MAG_W + 1)'(OUT_LIM);
   localparam logic signed [MAG_W:0]   AVG_LO      = (MAG_W + 1)'(-OUT_LIM);

   back_state_type              state_ff, state_in;
   logic signed [VEC_W-1:0]     vec_a_ff, vec_a_in;
   logic signed [VEC_W-1:0]     vec_b_ff, vec_b_in;
   logic signed [ANG_W-1:0]     angle_ff, angle_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic signed [HEAD_W-1:0]    head_ff, head_in;
   logic signed [SUM_W-1:0]     sum_ff, sum_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic signed [SUM_W-1:0]     group_sum_ff, group_sum_in;
   logic [MAG_W-1:0]            quot_ff, quot_in;
   logic                        neg_ff, neg_in;

   logic signed [OUT_W-1:0]     rsp_mem_ff [RSP_DEPTH];
   logic [RPTR_W-1:0]           rsp_wr_ff, rsp_wr_in;
   logic [RPTR_W-1:0]           rsp_rd_ff, rsp_rd_in;
   logic [RCNT_W-1:0]           rsp_cnt_ff, rsp_cnt_in;

   logic signed [VEC_W-1:0]     shift_a, shift_b;
   logic signed [ANG_W-1:0]     atan_step;
   logic signed [ANG_W-1:0]     rounded;
   logic signed [TOT_W-1:0]     total, trunc;
   logic [CNT_W-1:0]            count_next;
   logic signed [MAG_W:0]       group_wide, mag_wide;
   logic [PROD_W-1:0]           product;
   logic signed [MAG_W:0]       avg_wide;
   logic signed [OUT_W-1:0]     avg_out;
   logic                        rsp_push, rsp_take, rsp_full;

   // CORDIC micro-rotation operands
   assign shift_a   = vec_a_ff >>> step_ff;
   assign shift_b   = vec_b_ff >>> step_ff;
   assign atan_step = ANG_W'(ATAN_Q16[step_ff]);

   // Round Q16 angle to nearest, ties upward
   assign rounded = (angle_ff + ANG_W'(ROUND_HALF)) >>> ROUND_SHIFT;

   // Add heading to the sum, truncate toward zero
   assign total = (TOT_W'(sum_ff) <<< ANGLE_FRAC_BITS) + TOT_W'(head_ff);
   assign trunc = (total >>> ANGLE_FRAC_BITS)
                + $signed(TOT_W'(total[TOT_W-1] && (total[ANGLE_FRAC_BITS-1:0] != '0)));
   assign count_next = count_ff + 1'b1;

   // Magnitude times reciprocal gives the truncated quotient
   assign group_wide = (MAG_W + 1)'(group_sum_ff);
   assign mag_wide   = group_sum_ff[SUM_W-1] ? -group_wide : group_wide;
   assign product    = PROD_W'(mag_wide[MAG_W-1:0]) * PROD_W'(RECIP);

   // Restore sign and clamp the average
   always_comb begin
      avg_wide = neg_ff ? -$signed({1'b0, quot_ff}) : $signed({1'b0, quot_ff});
      if (avg_wide > AVG_HI) begin
         avg_out = OUT_W'(OUT_LIM);
      end else if (avg_wide < AVG_LO) begin
         avg_out = OUT_W'(-OUT_LIM);
      end else begin
         avg_out = avg_wide[OUT_W-1:0];
      end
   end

   assign rsp_full  = rsp_cnt_ff == RCNT_W'(RSP_DEPTH);
   assign rsp_empty = rsp_cnt_ff == '0;
   assign rsp_take  = rsp_pop && !rsp_empty;
   assign rsp_push  = (state_ff == ST_EMIT) && !rsp_full;
   assign rsp_heading_deg = rsp_mem_ff[rsp_rd_ff];
   assign work_take = (state_ff == ST_IDLE) && work_valid;

   // Sequencer and datapath
   always_comb begin
      state_in     = state_ff;
      vec_a_in     = vec_a_ff;
      vec_b_in     = vec_b_ff;
      angle_in     = angle_ff;
      step_in      = step_ff;
      head_in      = head_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      group_sum_in = group_sum_ff;
      quot_in      = quot_ff;
      neg_in       = neg_ff;
      unique case (state_ff)
         ST_IDLE: begin
            // Load the next reading
            if (work_valid) begin
               vec_a_in = VEC_W'(work.vec_a) <<< TABLE_FRAC;
               vec_b_in = VEC_W'(work.vec_b) <<< TABLE_FRAC;
               step_in  = '0;
               head_in  = work.fixed_heading;
               case (work.start)
                  START_POS90: angle_in = ANG_W'(ANGLE_RIGHT);
                  START_NEG90: angle_in = ANG_W'(-ANGLE_RIGHT);
                  default:     angle_in = '0;
               endcase
               state_in = work.special ? ST_ACCUM : ST_ROTATE;
            end
         end
         ST_ROTATE: begin
            // One rotation toward the positive X axis
            if (!vec_a_ff[VEC_W-1]) begin
               vec_b_in = vec_b_ff + shift_a;
               vec_a_in = vec_a_ff - shift_b;
               angle_in = angle_ff + atan_step;
            end else begin
               vec_b_in = vec_b_ff - shift_a;
               vec_a_in = vec_a_ff + shift_b;
               angle_in = angle_ff - atan_step;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            // Round and clamp to +-180 degrees
            if (rounded > ANG_HEAD_HI) begin
               head_in = HEAD_W'(HEAD_LIM);
            end else if (rounded < ANG_HEAD_LO) begin
               head_in = HEAD_W'(-HEAD_LIM);
            end else begin
               head_in = rounded[HEAD_W-1:0];
            end
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            // Saturate the new sum and count the reading
            if (trunc > TOT_SUM_HI) begin
               sum_in = SUM_W'(SUM_MAX);
            end else if (trunc < TOT_SUM_LO) begin
               sum_in = SUM_W'(SUM_MIN);
            end else begin
               sum_in = trunc[SUM_W-1:0];
            end
            count_in = count_next;
            state_in = ST_IDLE;
            if (count_next == CNT_W'(SAMPLES)) begin
               group_sum_in = sum_in;
               sum_in       = '0;
               count_in     = '0;
               state_in     = ST_AVG;
            end
         end
         ST_AVG: begin
            quot_in  = product[DIV_SHIFT +: MAG_W];
            neg_in   = group_sum_ff[SUM_W-1];
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // Hold until the result buffer has room
            if (!rsp_full) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result buffer pointers
   always_comb begin
      rsp_wr_in  = rsp_wr_ff;
      rsp_rd_in  = rsp_rd_ff;
      rsp_cnt_in = rsp_cnt_ff;
      if (rsp_push) begin
         rsp_wr_in = (rsp_wr_ff == RPTR_W'(RSP_DEPTH - 1)) ? '0 : rsp_wr_ff + 1'b1;
      end
      if (rsp_take) begin
         rsp_rd_in = (rsp_rd_ff == RPTR_W'(RSP_DEPTH - 1)) ? '0 : rsp_rd_ff + 1'b1;
      end
      if (rsp_push && !rsp_take) begin
         rsp_cnt_in = rsp_cnt_ff + 1'b1;
      end else if (rsp_take && !rsp_push) begin
         rsp_cnt_in = rsp_cnt_ff - 1'b1;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         sum_ff     <= '0;
         count_ff   <= '0;
         rsp_wr_ff  <= '0;
         rsp_rd_ff  <= '0;
         rsp_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         sum_ff     <= sum_in;
         count_ff   <= count_in;
         rsp_wr_ff  <= rsp_wr_in;
         rsp_rd_ff  <= rsp_rd_in;
         rsp_cnt_ff <= rsp_cnt_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      vec_a_ff     <= vec_a_in;
      vec_b_ff     <= vec_b_in;
      angle_ff     <= angle_in;
      step_ff      <= step_in;
      head_ff      <= head_in;
      group_sum_ff <= group_sum_in;
      quot_ff      <= quot_in;
      neg_ff       <= neg_in;
      if (rsp_push) begin
         rsp_mem_ff[rsp_wr_ff] <= avg_out;
      end
   end

endmodule

/* sv/cha_checker.sv */
// Port-level checks for compass_heading_averager, bound to the top level.
// Depends on cha_pkg and compass_heading_averager_assert.svh.
`include "compass_heading_averager_assert.svh"

module cha_checker import cha_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_full,
   input logic                    rsp_pop,
   input logic                    rsp_empty,
   input logic signed [OUT_W-1:0] rsp_heading_deg
);

   logic heading_in_range;

   assign heading_in_range = (rsp_heading_deg <= OUT_W'(OUT_LIM))
                          && (rsp_heading_deg >= OUT_W'(-OUT_LIM));

   // Reset leaves both sides empty and ready
   `CHA_ASSERT_RESET(a_reset_clears, rsp_empty && !req_full)

   // An average never leaves the +-180 degree range
   `CHA_ASSERT_HOLD(a_heading_range, !rsp_empty, heading_in_range)

   // A waiting result stays put until popped
   `CHA_ASSERT_NEXT(a_result_holds, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_heading_deg))

endmodule

bind compass_heading_averager cha_checker u_cha_checker (.*);
